FILE: rtl/assert_macros.svh
// Assertion macros shared by the score table RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with synchronous reset masking.
`define LVE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define LVE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lvest_pkg.sv
// Types, codes and constants for the least-value evict score table.
// No dependencies.
package lvest_pkg;

  localparam int TableDepth = 16;
  localparam int IdxW       = 4;
  localparam int CntW       = 5;
  localparam int IdW        = 32;
  localparam int ScoreW     = 16;
  localparam int CfgW       = 16;

  localparam logic [1:0] OP_MEET  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_DECAY = 2'd2;

  localparam logic [1:0] CFG_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_MAX      = 2'd1;
  localparam logic [1:0] CFG_UPPER    = 2'd2;
  localparam logic [1:0] CFG_MIDDLE   = 2'd3;

  localparam logic [1:0] TIER_NONE   = 2'd0;
  localparam logic [1:0] TIER_MIDDLE = 2'd1;
  localparam logic [1:0] TIER_UPPER  = 2'd2;

  localparam logic [IdW-1:0] NoId = '1;

  typedef struct packed {
    logic [1:0]        op;
    logic signed [31:0] other_id;
    logic [15:0]       amount;
  } lvest_in_t;

  typedef struct packed {
    logic [15:0] score;
    logic [1:0]  tier;
    logic [4:0]  entry_count;
  } lvest_out_t;

  typedef struct packed {
    logic              id_we;
    logic              score_we;
    logic [IdW-1:0]    id;
    logic [ScoreW-1:0] score;
  } lvest_cell_wr_t;

  typedef struct packed {
    logic              found;
    logic [ScoreW-1:0] score;
  } lvest_match_t;

endpackage

FILE: rtl/lvest_cell.sv
// One table entry: id and score storage, key compare, first-match chain stage.
// Depends on lvest_pkg.
module lvest_cell
  import lvest_pkg::*;
(
  input  logic              clk,
  input  logic              live,
  input  logic [IdW-1:0]    key,
  input  lvest_cell_wr_t    wr,
  input  lvest_match_t      chain_in,
  output lvest_match_t      chain_out,
  output logic              hit,
  output logic [IdW-1:0]    id,
  output logic [ScoreW-1:0] score
);

  always_ff @(posedge clk) begin
    if (wr.id_we) begin
      id <= wr.id;
    end
    if (wr.score_we) begin
      score <= wr.score;
    end
  end

  assign hit = live && (id == key);

  always_comb begin
    chain_out = chain_in;
    if (!chain_in.found && hit) begin
      chain_out.found = 1'b1;
      chain_out.score = score;
    end
  end

endmodule

FILE: rtl/least_value_evict_score_table.sv
// Top level of the least-value evict score table: cell row, sequencer, config.
// Depends on lvest_pkg, lvest_cell and assert_macros.svh.
//
// One transaction in, one result out. The table is a row of 16 cells that
// compare a key in parallel and pass the first match down the row. A query
// or a hit on meet goes from the lookup straight to the result; a meet on a
// new id with the table at capacity walks the scores for the minimum, then
// evicts and appends; a decay walks the entries from the top down. The
// sequencer handles one transaction at a time; the result waits in an
// output register until taken.
`include "assert_macros.svh"

module least_value_evict_score_table
  import lvest_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  lvest_in_t        in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output lvest_out_t       out_item,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CfgW-1:0]  cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LOOK   = 7'b0000010,
    S_MIN    = 7'b0000100,
    S_EVICT  = 7'b0001000,
    S_APPEND = 7'b0010000,
    S_DECAY  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [4:0]        capacity;
  logic [ScoreW-1:0] max_score;
  logic [ScoreW-1:0] upper_level;
  logic [ScoreW-1:0] middle_level;

  logic [1:0]        op;
  logic [IdW-1:0]    key;
  logic [ScoreW-1:0] amt;

  logic [CntW-1:0]   count;
  logic [CntW-1:0]   scan;
  logic [IdxW-1:0]   min_idx;
  logic [ScoreW-1:0] min_score;
  logic [IdxW-1:0]   dk;
  logic [ScoreW-1:0] res_score;
  logic [1:0]        res_tier;

  logic [IdW-1:0]    cell_id    [TableDepth];
  logic [ScoreW-1:0] cell_score [TableDepth];
  logic              cell_hit   [TableDepth];
  lvest_cell_wr_t    cell_wr    [TableDepth];
  lvest_match_t      chain      [TableDepth+1];

  logic [CntW-1:0]   eff_cap;
  logic [IdxW-1:0]   last_idx;
  logic [IdxW-1:0]   rd_a_idx;
  logic [ScoreW-1:0] rd_a_score;
  logic [IdW-1:0]    rd_b_id;
  logic [ScoreW-1:0] rd_b_score;
  logic [ScoreW:0]   hit_sum;
  logic [ScoreW-1:0] hit_new;
  logic [ScoreW-1:0] amt_sat;
  logic              found;
  logic [ScoreW-1:0] found_score;

  assign chain[0] = '0;

  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    lvest_cell u_cell (
      .clk       (clk),
      .live      (CntW'(g) < count),
      .key       (key),
      .wr        (cell_wr[g]),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .hit       (cell_hit[g]),
      .id        (cell_id[g]),
      .score     (cell_score[g])
    );
  end

  assign found       = chain[TableDepth].found;
  assign found_score = chain[TableDepth].score;

  always_comb begin
    eff_cap = capacity;
    if (capacity == '0) begin
      eff_cap = CntW'(1);
    end else if (capacity > CntW'(TableDepth)) begin
      eff_cap = CntW'(TableDepth);
    end
  end

  assign last_idx   = IdxW'(count - CntW'(1));
  assign rd_a_idx   = (state == S_DECAY) ? dk : scan[IdxW-1:0];
  assign rd_a_score = cell_score[rd_a_idx];
  assign rd_b_id    = cell_id[last_idx];
  assign rd_b_score = cell_score[last_idx];
  assign hit_sum    = {1'b0, found_score} + {1'b0, amt};
  assign hit_new    = (hit_sum < {1'b0, max_score}) ? hit_sum[ScoreW-1:0] : max_score;
  assign amt_sat    = (amt < max_score) ? amt : max_score;

  // Per-cell write commands.
  always_comb begin
    for (int i = 0; i < TableDepth; i++) begin
      cell_wr[i] = '0;
      unique case (state)
        S_LOOK: begin
          cell_wr[i].score = hit_new;
          cell_wr[i].score_we = (op == OP_MEET) && (key != NoId) && cell_hit[i];
        end
        S_EVICT: begin
          cell_wr[i].id = rd_b_id;
          cell_wr[i].score = rd_b_score;
          cell_wr[i].id_we = (min_idx == IdxW'(i));
          cell_wr[i].score_we = (min_idx == IdxW'(i));
        end
        S_APPEND: begin
          cell_wr[i].id = key;
          cell_wr[i].score = amt_sat;
          cell_wr[i].id_we = (count < CntW'(TableDepth)) && (count == CntW'(i));
          cell_wr[i].score_we = cell_wr[i].id_we;
        end
        S_DECAY: begin
          if (rd_a_score <= amt) begin
            cell_wr[i].id = rd_b_id;
            cell_wr[i].score = rd_b_score;
            cell_wr[i].id_we = (dk == IdxW'(i));
          end else begin
            cell_wr[i].score = rd_a_score - amt;
          end
          cell_wr[i].score_we = (dk == IdxW'(i));
        end
        default: begin
          cell_wr[i] = '0;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = S_DONE;
        if (op == OP_MEET && key != NoId && !found) begin
          if (count >= eff_cap && count != '0) begin
            state_next = S_MIN;
          end else begin
            state_next = S_APPEND;
          end
        end else if (op == OP_DECAY && amt != '0 && count != '0) begin
          state_next = S_DECAY;
        end
      end
      S_MIN: begin
        if (scan >= count) begin
          state_next = S_EVICT;
        end
      end
      S_EVICT:  state_next = S_APPEND;
      S_APPEND: state_next = S_DONE;
      S_DECAY: begin
        if (dk == '0) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      out_valid    <= 1'b0;
      capacity     <= 5'd16;
      max_score    <= 16'hFFFF;
      upper_level  <= 16'hC000;
      middle_level <= 16'h4000;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CAPACITY: capacity     <= cfg_data[4:0];
          CFG_MAX:      max_score    <= cfg_data;
          CFG_UPPER:    upper_level  <= cfg_data;
          CFG_MIDDLE:   middle_level <= cfg_data;
          default:      capacity     <= capacity;
        endcase
      end
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_EVICT: count <= count - CntW'(1);
        S_APPEND: begin
          if (count < CntW'(TableDepth)) begin
            count <= count + CntW'(1);
          end
        end
        S_DECAY: begin
          if (rd_a_score <= amt) begin
            count <= count - CntW'(1);
          end
        end
        default: count <= count;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op  <= in_item.op;
        key <= in_item.other_id;
        amt <= in_item.amount;
      end
      S_LOOK: begin
        res_score <= '0;
        res_tier  <= TIER_NONE;
        if (op == OP_QUERY) begin
          logic [ScoreW-1:0] s;
          s = (found && key != NoId) ? found_score : '0;
          res_score <= s;
          if (s >= upper_level) begin
            res_tier <= TIER_UPPER;
          end else if (s >= middle_level) begin
            res_tier <= TIER_MIDDLE;
          end
        end
        scan      <= CntW'(1);
        min_idx   <= '0;
        min_score <= cell_score[0];
        dk        <= last_idx;
      end
      S_MIN: begin
        if (scan < count) begin
          if (rd_a_score < min_score) begin
            min_score <= rd_a_score;
            min_idx   <= scan[IdxW-1:0];
          end
          scan <= scan + CntW'(1);
        end
      end
      S_DECAY: begin
        dk <= dk - IdxW'(1);
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_item.score       <= res_score;
          out_item.tier        <= res_tier;
          out_item.entry_count <= count;
        end
      end
      default: begin
        dk <= dk;
      end
    endcase
  end

  `LVE_ASSERT(a_count_bound, count <= CntW'(TableDepth), "entry count above table depth")
  `LVE_ASSERT_NEXT(a_accept_look, in_valid && !in_stall, state == S_LOOK, "accept did not start lookup")
  `LVE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `LVE_ASSERT_NEXT(a_decay_no_grow, state == S_DECAY, count <= $past(count), "decay grew the table")

endmodule

FILE: bench/tb_least_value_evict_score_table.sv
// Testbench for least_value_evict_score_table: a directed table, then random phases.
// Each phase uses its own register setting; an in-bench score table predicts every result but those typed in rows.
// Depends on lvest_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_least_value_evict_score_table;
  import lvest_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int NumPhases  = 6;
  localparam int PerPhase   = 105;
  localparam int NumRows    = 18;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  lvest_in_t        in_item = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  lvest_out_t       out_item;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = CFG_CAPACITY;
  logic [CfgW-1:0]  cfg_data = '0;

  least_value_evict_score_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted table contents and register copies
  logic [IdW-1:0]    tbl_id    [TableDepth];
  logic [ScoreW-1:0] tbl_score [TableDepth];
  int unsigned       tbl_count;
  logic [4:0]        capacity;
  logic [15:0]       ceiling, upper_lvl, middle_lvl;

  lvest_out_t        pending_results[$];
  logic [IdW-1:0]    id_pool[24];
  int                errors = 0;
  int                accepted = 0;
  int                cycles = 0;
  bit                held_off = 0;

  function automatic void drop_entry(int unsigned idx);
    tbl_id[idx]    = tbl_id[tbl_count-1];
    tbl_score[idx] = tbl_score[tbl_count-1];
    tbl_count--;
  endfunction

  function automatic lvest_out_t table_step(lvest_in_t it);
    lvest_out_t   r;
    logic [IdW-1:0] key;
    logic [16:0]  sum;
    int unsigned  cap_eff;
    int unsigned  low;
    bit           hit;
    r   = '0;
    key = it.other_id;
    hit = 0;
    case (it.op)
      OP_MEET: begin
        if (key != NoId) begin
          for (int unsigned i = 0; i < tbl_count; i++) begin
            if (!hit && tbl_id[i] == key) begin
              sum = tbl_score[i] + it.amount;
              tbl_score[i] = (sum < ceiling) ? sum[15:0] : ceiling;
              hit = 1;
            end
          end
          if (!hit) begin
            cap_eff = (capacity == 0) ? 1 : (capacity > TableDepth) ? TableDepth : capacity;
            if (tbl_count >= cap_eff && tbl_count > 0) begin
              low = 0;
              for (int unsigned i = 1; i < tbl_count; i++)
                if (tbl_score[i] < tbl_score[low]) low = i;
              drop_entry(low);
            end
            if (tbl_count < TableDepth) begin
              tbl_id[tbl_count]    = key;
              tbl_score[tbl_count] = (it.amount < ceiling) ? it.amount : ceiling;
              tbl_count++;
            end
          end
        end
      end
      OP_QUERY: begin
        if (key != NoId)
          for (int unsigned i = 0; i < tbl_count; i++)
            if (!hit && tbl_id[i] == key) begin
              r.score = tbl_score[i];
              hit = 1;
            end
        r.tier = (r.score >= upper_lvl) ? TIER_UPPER :
                 (r.score >= middle_lvl) ? TIER_MIDDLE : TIER_NONE;
      end
      OP_DECAY: begin
        if (it.amount != 0)
          for (int unsigned i = tbl_count; i > 0; i--) begin
            if (tbl_score[i-1] <= it.amount) drop_entry(i-1);
            else tbl_score[i-1] -= it.amount;
          end
      end
      default: ;
    endcase
    r.entry_count = tbl_count[4:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic offer(lvest_in_t it, bit typed, lvest_out_t typed_res);
    lvest_out_t r;
    int gap;
    in_valid <= 1'b1;
    in_item  <= it;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    accepted++;
    r = table_step(it);
    pending_results.push_back(typed ? typed_res : r);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller drops it after the last write
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_CAPACITY: capacity   = val[4:0];
      CFG_MAX:      ceiling    = val;
      CFG_UPPER:    upper_lvl  = val;
      default:      middle_lvl = val;
    endcase
  endtask

  function automatic lvest_in_t random_item();
    lvest_in_t it;
    int p;
    p = $urandom_range(0, 99);
    it.op = (p < 40) ? OP_MEET : (p < 75) ? OP_QUERY : (p < 94) ? OP_DECAY : 2'd3;
    p = $urandom_range(0, 99);
    if (p < 88) it.other_id = id_pool[$urandom_range(0, 23)];
    else if (p < 94) it.other_id = NoId;
    else it.other_id = {1'b0, 31'($urandom)};
    p = $urandom_range(0, 99);
    if (it.op == OP_DECAY)
      it.amount = (p < 10) ? 16'h0 : (p < 13) ? 16'hFFFF : 16'($urandom_range(1, 'h600));
    else
      it.amount = (p < 10) ? 16'h0 : (p < 20) ? 16'hFFFF :
                  (p < 70) ? 16'($urandom_range(1, 'h1000)) : 16'($urandom);
    return it;
  endfunction

  // Receiver: random stalls, one long hold-off so the block backs up
  int hold_left = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("least_value_evict_score_table test failed");
      $finish;
    end
    if (!held_off && accepted >= 60) begin
      held_off  <= 1;
      hold_left <= 200;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 25) ||
                   (out_stall && $urandom_range(0, 99) < 60);
    end
  end

  always @(posedge clk) begin
    lvest_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction %p", $time, out_item);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.score !== want.score) begin
          $display("%0t: score expected %h got %h", $time, want.score, out_item.score);
          errors++;
        end
        if (out_item.tier !== want.tier) begin
          $display("%0t: tier expected %0d got %0d", $time, want.tier, out_item.tier);
          errors++;
        end
        if (out_item.entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d got %0d", $time,
                   want.entry_count, out_item.entry_count);
          errors++;
        end
      end
    end
  end

  typedef struct {
    lvest_in_t  stim;
    bit         typed;
    lvest_out_t res;
  } row_t;

  row_t        rows[NumRows];
  logic [15:0] phase_cfg[NumPhases][4];

  initial begin
    rows = '{
      '{'{OP_QUERY, 32'sd5,        16'h0000}, 1, '{16'h0000, TIER_NONE, 5'd0}},
      '{'{OP_MEET,  NoId,          16'hFFFF}, 1, '{16'h0000, TIER_NONE, 5'd0}},
      '{'{OP_MEET,  32'h7FFFFFFF,  16'hFFFF}, 1, '{16'h0000, TIER_NONE, 5'd1}},
      '{'{OP_QUERY, 32'h7FFFFFFF,  16'h0000}, 1, '{16'hFFFF, TIER_UPPER, 5'd1}},
      '{'{OP_MEET,  32'sd0,        16'h0000}, 1, '{16'h0000, TIER_NONE, 5'd2}},
      '{'{OP_QUERY, 32'sd0,        16'hFFFF}, 1, '{16'h0000, TIER_NONE, 5'd2}},
      '{'{2'd3,     32'sd0,        16'h1234}, 1, '{16'h0000, TIER_NONE, 5'd2}},
      '{'{OP_MEET,  32'h7FFFFFFF,  16'h0001}, 1, '{16'h0000, TIER_NONE, 5'd2}},
      '{'{OP_DECAY, 32'sd0,        16'h0000}, 1, '{16'h0000, TIER_NONE, 5'd2}},
      '{'{OP_MEET,  32'sd1,        16'h4000}, 0, '{16'h0, TIER_NONE, 5'd0}},
      '{'{OP_MEET,  32'sd2,        16'h4000}, 0, '{16'h0, TIER_NONE, 5'd0}},
      '{'{OP_MEET,  32'sd3,        16'hC000}, 0, '{16'h0, TIER_NONE, 5'd0}},
      '{'{OP_QUERY, 32'sd1,        16'h0000}, 0, '{16'h0, TIER_NONE, 5'd0}},
      '{'{OP_QUERY, 32'sd3,        16'h0000}, 0, '{16'h0, TIER_NONE, 5'd0}},
      '{'{OP_QUERY, NoId,          16'h0000}, 0, '{16'h0, TIER_NONE, 5'd0}},
      '{'{OP_DECAY, 32'sd0,        16'h4000}, 0, '{16'h0, TIER_NONE, 5'd0}},
      '{'{OP_QUERY, 32'h7FFFFFFF,  16'h0000}, 0, '{16'h0, TIER_NONE, 5'd0}},
      '{'{OP_DECAY, 32'sd0,        16'hFFFF}, 1, '{16'h0000, TIER_NONE, 5'd0}}
    };
    phase_cfg = '{
      '{16'd16, 16'hFFFF, 16'hC000, 16'h4000},
      '{16'd3,  16'h0800, 16'h0400, 16'h0200},
      '{16'd0,  16'hFFFF, 16'h0000, 16'h0000},
      '{16'd31, 16'h0000, 16'hFFFF, 16'hFFFF},
      '{16'd1,  16'h1234, 16'h1000, 16'h0800},
      '{16'd16, 16'hFFFF, 16'h8000, 16'h0100}
    };
    tbl_count  = 0;
    capacity   = 5'd16;
    ceiling    = 16'hFFFF;
    upper_lvl  = 16'hC000;
    middle_lvl = 16'h4000;
    id_pool[0] = '0;
    id_pool[1] = 32'h7FFFFFFF;
    for (int i = 2; i < 24; i++) id_pool[i] = {1'b0, 31'($urandom)};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) offer(rows[i].stim, rows[i].typed, rows[i].res);
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      for (int r = 0; r < 4; r++) write_reg(r[1:0], phase_cfg[ph][r]);
      cfg_we <= 1'b0;
      for (int n = 0; n < PerPhase; n++) offer(random_item(), 0, '0);
      drain();
    end

    if (errors == 0) begin
      $display("least_value_evict_score_table test passed");
    end else begin
      $display("least_value_evict_score_table test failed");
    end
    $finish;
  end

endmodule
